FILE: rtl/core/cmh_pkg.sv
`timescale 1ns / 1ps
package cmh_pkg;

   // Default build-time settings
   localparam int DEF_ANGLE_STEPS   = 16;
   localparam int DEF_FRACTION_BITS = 16;

   // Field and register widths
   localparam int AXIS_W     = 16;
   localparam int SCALE_W    = 12;
   localparam int SCALE_FRAC = 8;
   localparam int PROD_W     = AXIS_W + SCALE_W + 1;
   localparam int MAG_W      = 20;
   localparam int HEAD_W     = 19;
   localparam int DEG_W      = 16;
   localparam int A16_W      = 20;

   // CORDIC datapath
   localparam int GUARD_SHIFT = 10;
   localparam int CORDIC_W    = MAG_W + GUARD_SHIFT + 4;
   localparam int ATAN_LEN    = 24;

   // Register map
   localparam int CSR_INDEX_W = 1;
   localparam int CSR_DATA_W  = 19;
   localparam logic [CSR_INDEX_W-1:0] CSR_FIELD_SCALE = 1'b0;
   localparam logic [CSR_INDEX_W-1:0] CSR_DECLINATION = 1'b1;
   localparam logic [SCALE_W-1:0]     FIELD_SCALE_RST = 12'd655;
   localparam logic [HEAD_W-1:0]      DECLINATION_RST = 19'd4822;

   // Angle constants
   localparam logic [HEAD_W-1:0] TWO_PI_Q16 = 19'd411775;
   localparam logic [HEAD_W-1:0] HEAD_MAX   = 19'd411774;
   localparam logic [28:0]       DEG_MUL    = 29'd480632043;

   localparam longint unsigned HALF_PI_Q30       = 64'd1686629713;
   localparam longint unsigned PI_Q30            = 64'd3373259426;
   localparam longint unsigned THREE_HALF_PI_Q30 = 64'd5059889139;
   localparam longint unsigned TWO_PI_Q30        = 64'd6746518852;

   localparam longint unsigned ATAN_Q30 [ATAN_LEN] = '{
      64'd843314857, 64'd497837829, 64'd263043837, 64'd133525159,
      64'd67021687,  64'd33543516,  64'd16775851,  64'd8388437,
      64'd4194283,   64'd2097149,   64'd1048576,   64'd524288,
      64'd262144,    64'd131072,    64'd65536,     64'd32768,
      64'd16384,     64'd8192,      64'd4096,      64'd2048,
      64'd1024,      64'd512,       64'd256,       64'd128
   };

   // How the final angle is formed from the CORDIC result
   typedef enum logic [2:0] {
      SEL_ZERO,
      SEL_HALF_PI,
      SEL_PI,
      SEL_THREE_HALF_PI,
      SEL_Q1,
      SEL_Q2,
      SEL_Q3,
      SEL_Q4
   } cmh_sel_type;

   typedef struct packed {
      logic [7:0] x_high_byte;
      logic [7:0] x_low_byte;
      logic [7:0] y_high_byte;
      logic [7:0] y_low_byte;
   } cmh_req_type;

   typedef struct packed {
      logic [HEAD_W-1:0] heading_radians;
      logic [DEG_W-1:0]  heading_degrees;
   } cmh_rsp_type;

   // Round a Q30 constant half up to Q(fb)
   function automatic longint unsigned q30_to_frac(input longint unsigned v, input int fb);
      return (v + (64'd1 << (29 - fb))) >> (30 - fb);
   endfunction

endpackage

FILE: rtl/core/cmh_cordic.sv
`timescale 1ns / 1ps
module cmh_cordic #(
   parameter int ANGLE_STEPS   = cmh_pkg::DEF_ANGLE_STEPS,
   parameter int FRACTION_BITS = cmh_pkg::DEF_FRACTION_BITS
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              in_valid,
   output logic                              in_ready,
   input  logic [cmh_pkg::MAG_W-1:0]         in_x_mag,
   input  logic [cmh_pkg::MAG_W-1:0]         in_y_mag,
   input  cmh_pkg::cmh_sel_type              in_sel,
   output logic                              out_valid,
   input  logic                              out_ready,
   output logic signed [FRACTION_BITS+2:0]   out_z,
   output cmh_pkg::cmh_sel_type              out_sel
);
   import cmh_pkg::*;

   localparam int ZW    = FRACTION_BITS + 3;
   localparam int STEPS = (ANGLE_STEPS < ATAN_LEN) ? ANGLE_STEPS : ATAN_LEN;

   logic signed [CORDIC_W-1:0] x_ff [0:STEPS-1];
   logic signed [CORDIC_W-1:0] y_ff [0:STEPS-1];
   logic signed [ZW-1:0]       z_ff [0:STEPS-1];
   cmh_sel_type                sel_ff [0:STEPS-1];
   logic                       vld_ff [0:STEPS-1];
   logic                       stage_ready [0:STEPS];

   assign stage_ready[STEPS] = out_ready;

   for (genvar k = 0; k < STEPS; k++) begin : g_stage
      localparam logic signed [ZW-1:0] ATAN_K = ZW'(q30_to_frac(ATAN_Q30[k], FRACTION_BITS));

      logic signed [CORDIC_W-1:0] x_cur;
      logic signed [CORDIC_W-1:0] y_cur;
      logic signed [ZW-1:0]       z_cur;
      cmh_sel_type                sel_cur;
      logic                       v_cur;
      logic signed [CORDIC_W-1:0] x_in;
      logic signed [CORDIC_W-1:0] y_in;
      logic signed [ZW-1:0]       z_in;

      if (k == 0) begin : g_first
         assign x_cur   = CORDIC_W'({in_x_mag, GUARD_SHIFT'(0)});
         assign y_cur   = CORDIC_W'({in_y_mag, GUARD_SHIFT'(0)});
         assign z_cur   = '0;
         assign sel_cur = in_sel;
         assign v_cur   = in_valid;
      end else begin : g_next
         assign x_cur   = x_ff[k-1];
         assign y_cur   = y_ff[k-1];
         assign z_cur   = z_ff[k-1];
         assign sel_cur = sel_ff[k-1];
         assign v_cur   = vld_ff[k-1];
      end

      assign stage_ready[k] = !vld_ff[k] || stage_ready[k+1];

      // Rotate towards the X axis, steering by the sign of Y
      always_comb begin
         if (!y_cur[CORDIC_W-1]) begin
            x_in = x_cur + (y_cur >>> k);
            y_in = y_cur - (x_cur >>> k);
            z_in = z_cur + ATAN_K;
         end else begin
            x_in = x_cur - (y_cur >>> k);
            y_in = y_cur + (x_cur >>> k);
            z_in = z_cur - ATAN_K;
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            vld_ff[k] <= 1'b0;
         end else if (stage_ready[k]) begin
            vld_ff[k] <= v_cur;
         end
      end

      always_ff @(posedge clock) begin
         if (stage_ready[k]) begin
            x_ff[k]   <= x_in;
            y_ff[k]   <= y_in;
            z_ff[k]   <= z_in;
            sel_ff[k] <= sel_cur;
         end
      end
   end

   assign in_ready  = stage_ready[0];
   assign out_valid = vld_ff[STEPS-1];
   assign out_z     = z_ff[STEPS-1];
   assign out_sel   = sel_ff[STEPS-1];

endmodule

FILE: rtl/core/compass_heading_from_magnetometer_top.sv
`timescale 1ns / 1ps
// Throughput: one transaction per cycle while rsp_ready holds; the CORDIC runs one iteration per
// pipeline stage, so the stage count, not any shared unit, sets the latency.
// Reset (synchronous, active high): empties every stage and loads field_scale = 655 and
// declination = 4822 (Q16 radians).
module compass_heading_from_magnetometer_top #(
   parameter int ANGLE_STEPS   = cmh_pkg::DEF_ANGLE_STEPS,
   parameter int FRACTION_BITS = cmh_pkg::DEF_FRACTION_BITS
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_ready,
   input  cmh_pkg::cmh_req_type               req_data,
   output logic                               rsp_valid,
   input  logic                               rsp_ready,
   output cmh_pkg::cmh_rsp_type               rsp_data,
   input  logic                               csr_wr_en,
   input  logic [cmh_pkg::CSR_INDEX_W-1:0]    csr_index,
   input  logic [cmh_pkg::CSR_DATA_W-1:0]     csr_wdata
);
   import cmh_pkg::*;

   // Angle width in Q(FRACTION_BITS): holds up to 2*pi, and the signed CORDIC sum
   localparam int AW = FRACTION_BITS + 3;
   localparam int SHIFT_DN = (FRACTION_BITS > 16) ? FRACTION_BITS - 16 : 0;
   localparam int SHIFT_UP = (FRACTION_BITS < 16) ? 16 - FRACTION_BITS : 0;

   localparam logic [AW-1:0] HALF_PI       = AW'(q30_to_frac(HALF_PI_Q30, FRACTION_BITS));
   localparam logic [AW-1:0] PI_FRAC       = AW'(q30_to_frac(PI_Q30, FRACTION_BITS));
   localparam logic [AW-1:0] THREE_HALF_PI = AW'(q30_to_frac(THREE_HALF_PI_Q30, FRACTION_BITS));
   localparam logic [AW-1:0] TWO_PI_FRAC   = AW'(q30_to_frac(TWO_PI_Q30, FRACTION_BITS));

   // ------------------------------------------------------------------
   // Configuration registers: the user must write them only while the pipeline
   // is empty (the block does not enforce it), so every stage may read them directly.
   // ------------------------------------------------------------------
   logic [SCALE_W-1:0] field_scale_ff;
   logic [HEAD_W-1:0]  declination_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         field_scale_ff <= FIELD_SCALE_RST;
         declination_ff <= DECLINATION_RST;
      end else if (csr_wr_en) begin
         unique case (csr_index)
            CSR_FIELD_SCALE: field_scale_ff <= csr_wdata[SCALE_W-1:0];
            CSR_DECLINATION: declination_ff <= csr_wdata[HEAD_W-1:0];
         endcase
      end
   end

   // Backpressure chain: a stage takes new data when it is empty or its
   // successor is taking its contents, so bubbles collapse under a stall.
   logic s1_ready, s2_ready, cordic_in_ready;
   logic b1_ready, b2_ready, b3_ready, out_ready;

   // ------------------------------------------------------------------
   // Stage 1: form the signed axis words and apply the gain (Q8).
   // ------------------------------------------------------------------
   logic                     s1_vld_ff;
   logic signed [PROD_W-1:0] x_prod_ff, x_prod_in;
   logic signed [PROD_W-1:0] y_prod_ff, y_prod_in;
   logic signed [AXIS_W-1:0] raw_x, raw_y;
   logic signed [SCALE_W:0]  scale_s;

   assign s1_ready  = !s1_vld_ff || s2_ready;
   assign req_ready = s1_ready;

   always_comb begin
      raw_x     = $signed({req_data.x_high_byte, req_data.x_low_byte});
      raw_y     = $signed({req_data.y_high_byte, req_data.y_low_byte});
      scale_s   = $signed({1'b0, field_scale_ff});
      x_prod_in = PROD_W'(raw_x) * PROD_W'(scale_s);
      y_prod_in = PROD_W'(raw_y) * PROD_W'(scale_s);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_vld_ff <= 1'b0;
      end else if (s1_ready) begin
         s1_vld_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_ready) begin
         x_prod_ff <= x_prod_in;
         y_prod_ff <= y_prod_in;
      end
   end

   // ------------------------------------------------------------------
   // Stage 2: drop the gain fraction toward zero (truncate the magnitude),
   // take magnitudes for the first-quadrant CORDIC and classify the quadrant
   // and the on-axis cases.
   // ------------------------------------------------------------------
   logic              s2_vld_ff;
   logic [MAG_W-1:0]  x_mag_ff, x_mag_in;
   logic [MAG_W-1:0]  y_mag_ff, y_mag_in;
   cmh_sel_type       sel_ff, sel_in;
   logic [PROD_W-1:0] x_abs, y_abs;
   logic              x_neg, y_neg, x_zero, y_zero;

   assign s2_ready = !s2_vld_ff || cordic_in_ready;

   always_comb begin
      x_neg    = x_prod_ff[PROD_W-1];
      y_neg    = y_prod_ff[PROD_W-1];
      x_abs    = x_neg ? PROD_W'(-x_prod_ff) : PROD_W'(x_prod_ff);
      y_abs    = y_neg ? PROD_W'(-y_prod_ff) : PROD_W'(y_prod_ff);
      x_mag_in = x_abs[SCALE_FRAC+MAG_W-1:SCALE_FRAC];
      y_mag_in = y_abs[SCALE_FRAC+MAG_W-1:SCALE_FRAC];
      x_zero   = (x_mag_in == '0);
      y_zero   = (y_mag_in == '0);

      // Both axes zero falls into the zero-heading case
      priority if (y_zero && (x_zero || !x_neg)) begin
         sel_in = SEL_ZERO;
      end else if (x_zero) begin
         sel_in = y_neg ? SEL_THREE_HALF_PI : SEL_HALF_PI;
      end else if (y_zero) begin
         sel_in = SEL_PI;
      end else if (!x_neg && !y_neg) begin
         sel_in = SEL_Q1;
      end else if (x_neg && !y_neg) begin
         sel_in = SEL_Q2;
      end else if (x_neg) begin
         sel_in = SEL_Q3;
      end else begin
         sel_in = SEL_Q4;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_vld_ff <= 1'b0;
      end else if (s2_ready) begin
         s2_vld_ff <= s1_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (s2_ready) begin
         x_mag_ff <= x_mag_in;
         y_mag_ff <= y_mag_in;
         sel_ff   <= sel_in;
      end
   end

   // ------------------------------------------------------------------
   // Vectoring CORDIC: atan(|Y| / |X|), one iteration per stage.
   // ------------------------------------------------------------------
   logic                cordic_out_valid;
   logic signed [AW-1:0] cordic_z;
   cmh_sel_type         cordic_sel;

   cmh_cordic #(
      .ANGLE_STEPS   (ANGLE_STEPS),
      .FRACTION_BITS (FRACTION_BITS)
   ) u_cordic (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (s2_vld_ff),
      .in_ready  (cordic_in_ready),
      .in_x_mag  (x_mag_ff),
      .in_y_mag  (y_mag_ff),
      .in_sel    (sel_ff),
      .out_valid (cordic_out_valid),
      .out_ready (b1_ready),
      .out_z     (cordic_z),
      .out_sel   (cordic_sel)
   );

   // ------------------------------------------------------------------
   // Back stage 1: clamp the CORDIC angle to [0, pi/2] and unfold it into
   // the full circle.
   // ------------------------------------------------------------------
   logic          b1_vld_ff;
   logic [AW-1:0] angle_ff, angle_in;
   logic [AW-1:0] z_clamp;

   assign b1_ready = !b1_vld_ff || b2_ready;

   always_comb begin
      if (cordic_z[AW-1]) begin
         z_clamp = '0;
      end else if (AW'(cordic_z) > HALF_PI) begin
         z_clamp = HALF_PI;
      end else begin
         z_clamp = AW'(cordic_z);
      end

      unique case (cordic_sel)
         SEL_ZERO:          angle_in = '0;
         SEL_HALF_PI:       angle_in = HALF_PI;
         SEL_PI:            angle_in = PI_FRAC;
         SEL_THREE_HALF_PI: angle_in = THREE_HALF_PI;
         SEL_Q1:            angle_in = z_clamp;
         SEL_Q2:            angle_in = PI_FRAC - z_clamp;
         SEL_Q3:            angle_in = PI_FRAC + z_clamp;
         SEL_Q4:            angle_in = TWO_PI_FRAC - z_clamp;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         b1_vld_ff <= 1'b0;
      end else if (b1_ready) begin
         b1_vld_ff <= cordic_out_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (b1_ready) begin
         angle_ff <= angle_in;
      end
   end

   // ------------------------------------------------------------------
   // Back stage 2: bring the angle to Q16 (round half up when narrowing)
   // and fold a full turn back to zero.
   // ------------------------------------------------------------------
   logic              b2_vld_ff;
   logic [HEAD_W-1:0] a16_ff, a16_in;
   logic [A16_W-1:0]  a16_raw;

   assign b2_ready = !b2_vld_ff || b3_ready;

   if (FRACTION_BITS > 16) begin : g_narrow
      logic [AW:0] angle_rnd;
      assign angle_rnd = {1'b0, angle_ff} + (AW+1)'(1 << (SHIFT_DN - 1));
      assign a16_raw   = A16_W'(angle_rnd >> SHIFT_DN);
   end else if (FRACTION_BITS == 16) begin : g_same
      assign a16_raw = A16_W'(angle_ff);
   end else begin : g_widen
      assign a16_raw = A16_W'(angle_ff) << SHIFT_UP;
   end

   always_comb begin
      if (a16_raw >= A16_W'(TWO_PI_Q16)) begin
         a16_in = HEAD_W'(a16_raw - A16_W'(TWO_PI_Q16));
      end else begin
         a16_in = HEAD_W'(a16_raw);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         b2_vld_ff <= 1'b0;
      end else if (b2_ready) begin
         b2_vld_ff <= b1_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (b2_ready) begin
         a16_ff <= a16_in;
      end
   end

   // ------------------------------------------------------------------
   // Back stage 3: subtract the declination (held below a full turn),
   // wrapping below zero by adding one turn.
   // ------------------------------------------------------------------
   logic              b3_vld_ff;
   logic [HEAD_W-1:0] head_ff, head_in;
   logic [HEAD_W-1:0] decl_sat;

   assign b3_ready = !b3_vld_ff || out_ready;

   always_comb begin
      decl_sat = (declination_ff > HEAD_MAX) ? HEAD_MAX : declination_ff;
      if (a16_ff < decl_sat) begin
         head_in = HEAD_W'(A16_W'(a16_ff) + A16_W'(TWO_PI_Q16) - A16_W'(decl_sat));
      end else begin
         head_in = a16_ff - decl_sat;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         b3_vld_ff <= 1'b0;
      end else if (b3_ready) begin
         b3_vld_ff <= b2_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (b3_ready) begin
         head_ff <= head_in;
      end
   end

   // ------------------------------------------------------------------
   // Output register: degrees times 128 by a reciprocal multiply; hold the
   // transaction until the consumer takes it.
   // ------------------------------------------------------------------
   logic        rsp_valid_ff;
   cmh_rsp_type rsp_data_ff, rsp_data_in;
   logic [47:0] deg_prod;

   assign out_ready = !rsp_valid_ff || rsp_ready;

   always_comb begin
      deg_prod                    = 48'(head_ff) * 48'(DEG_MUL);
      rsp_data_in.heading_radians = head_ff;
      rsp_data_in.heading_degrees = deg_prod[47:32];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (out_ready) begin
         rsp_valid_ff <= b3_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (out_ready) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule
